[rtl/quadratic_probe_hash_table_defines.svh]
// assertion macros for the quadratic probe hash table
// used by the top level only; no other dependencies
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define QPHT_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qpht check failed");
`define QPHT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qpht check failed");
`else
`define QPHT_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define QPHT_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[rtl/qpht_pkg.sv]
// shared types, constants and helpers for the quadratic probe hash table
// no dependencies
package qpht_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FUNC_W        = 2;
    localparam int KEY_W         = 31;
    localparam int VAL_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 4;
    localparam int ENTRY_W       = 1 + KEY_W + VAL_W;
    localparam int KEY_BIT_W     = $clog2(KEY_W);

    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

    localparam logic [IDX_W:0]   ENTRIES_EXT = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
    // (i+1)^2 - i^2 = 2i+1, kept modulo the table size
    localparam logic [IDX_W-1:0] SQ_INIT     = IDX_W'(1 % TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] ODD_INIT    = IDX_W'(3 % TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] ODD_STEP    = IDX_W'(2 % TABLE_ENTRIES);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // result handed from the controller to the output register
    typedef struct packed {
        logic load;
        rsp_t rsp;
    } res_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } stat_t;

    // a + b modulo the table size, both operands already reduced
    function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ENTRIES_EXT)
            s = s - ENTRIES_EXT;
        return s[IDX_W-1:0];
    endfunction

endpackage

[rtl/qpht_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module qpht_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

[rtl/qpht_ctrl.sv]
// probe sequencer: clearing pass, home slot, quadratic probe walk, write back
// depends on qpht_pkg
module qpht_ctrl import qpht_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  req_t             req,
    input  logic             out_free,
    input  logic [ENTRY_W-1:0] rd_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output res_t             res,
    output stat_t            stat
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HOME  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    req_t                 req_reg, req_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     sq_reg, sq_next;
    logic [IDX_W-1:0]     odd_reg, odd_next;
    logic [IDX_W-1:0]     att_reg, att_next;
    logic [KEY_BIT_W-1:0] bit_reg, bit_next;
    logic [IDX_W-1:0]     home_reg, home_next;
    rsp_t                 hold_reg, hold_next;

    entry_t           entry;
    logic [IDX_W-1:0] pos_adv;
    logic [IDX_W:0]   home_shift;
    logic [IDX_W-1:0] home_step;
    logic             is_insert;
    logic             is_delete;
    logic             hit;
    logic             finish;
    rsp_t             fin_rsp;

    assign entry     = entry_t'(rd_data);
    assign pos_adv   = add_mod(pos_reg, sq_reg);
    assign is_insert = (req_reg.func == FUNC_INSERT);
    assign is_delete = (req_reg.func == FUNC_DELETE);

    // one bit of key mod table size per cycle, msb first
    always_comb
    begin
        home_shift = {home_reg, req_reg.key[bit_reg]};
        if (home_shift >= ENTRIES_EXT)
            home_shift = home_shift - ENTRIES_EXT;
        home_step = home_shift[IDX_W-1:0];
    end

    always_comb
    begin
        if (is_insert)
            hit = !entry.valid;
        else
            hit = entry.valid && (entry.key == req_reg.key)
                  && (entry.value == req_reg.value);
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req_next   = req_reg;
        pos_next   = pos_reg;
        sq_next    = sq_reg;
        odd_next   = odd_reg;
        att_next   = att_reg;
        bit_next   = bit_reg;
        home_next  = home_reg;
        hold_next  = hold_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = '0;
        finish     = 1'b0;
        fin_rsp    = '{status: STAT_MISS, slot_index: '0};
        res        = '{load: 1'b0, rsp: hold_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == LAST_IDX)
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    sq_next   = SQ_INIT;
                    odd_next  = ODD_INIT;
                    att_next  = '0;
                    bit_next  = KEY_BIT_W'(KEY_W - 1);
                    home_next = '0;
                    if (IS_POW2)
                    begin
                        pos_next   = req.key[IDX_W-1:0];
                        state_next = S_READ;
                    end
                    else
                        state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                home_next = home_step;
                if (bit_reg == '0)
                begin
                    pos_next   = home_step;
                    state_next = S_READ;
                end
                else
                    bit_next = bit_reg - 1'b1;
            end
            S_READ:
            begin
                if (is_insert || is_delete || (req_reg.func == FUNC_SEARCH))
                begin
                    rd_en      = 1'b1;
                    state_next = S_CHECK;
                end
                else
                    finish = 1'b1;  // unknown operation reports a miss
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    finish  = 1'b1;
                    fin_rsp = '{status: STAT_DONE, slot_index: SLOT_W'(pos_reg)};
                    wr_en   = is_insert || is_delete;
                    wr_data = is_insert ? {1'b1, req_reg.key, req_reg.value} : '0;
                end
                else if (att_reg == LAST_IDX)
                begin
                    finish         = 1'b1;
                    fin_rsp.status = is_insert ? STAT_FULL : STAT_MISS;
                end
                else
                begin
                    // fetch the next slot while this one is being checked
                    rd_en    = 1'b1;
                    rd_addr  = pos_adv;
                    pos_next = pos_adv;
                    sq_next  = add_mod(sq_reg, odd_reg);
                    odd_next = add_mod(odd_reg, ODD_STEP);
                    att_next = att_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                res        = '{load: 1'b1, rsp: fin_rsp};
                state_next = S_IDLE;
            end
            else
            begin
                hold_next  = fin_rsp;
                state_next = S_WAIT;
            end
        end
    end

    assign stat = '{clearing: (state_reg == S_CLEAR), idle: (state_reg == S_IDLE)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        pos_reg  <= pos_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
        att_reg  <= att_next;
        bit_reg  <= bit_next;
        home_reg <= home_next;
        hold_reg <= hold_next;
    end

endmodule

[rtl/quadratic_probe_hash_table.sv]
// top level of the quadratic probe hash table: slot ram, probe sequencer,
// output register and checks; depends on qpht_pkg, qpht_ram, qpht_ctrl
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_ready  req_t  {func, key, value}
//   rsp       out   rsp_valid / rsp_ready  rsp_t  {status, slot_index}
//
// after reset a clearing pass writes every slot invalid, with req_ready low. an item
// probes 1 .. TABLE_ENTRIES slots, one ram read each (none for an unknown operation);
// a non power of two size first reduces the key to its home slot one bit at a time.
// one item is in work at a time; the next is taken while the result register
// still waits on rsp_ready, and a full result register stalls the sequencer.
`include "quadratic_probe_hash_table_defines.svh"
module quadratic_probe_hash_table import qpht_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    res_t               res;
    stat_t              stat;
    logic               out_free;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = stat.idle;

    qpht_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .out_free  (out_free),
        .rd_data   (rd_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res       (res),
        .stat      (stat)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res.load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res.rsp;
        end
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `QPHT_ASSERT_SAME(a_slot_zero_on_fail, clk, rst_n, rsp_valid && (rsp.status != STAT_DONE), rsp.slot_index == '0)
    `QPHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `QPHT_ASSERT_SAME(a_quiet_while_clearing, clk, rst_n, stat.clearing, !rsp_valid && !req_ready)
    `QPHT_ASSERT_SAME(a_no_load_when_full, clk, rst_n, res.load, !rsp_valid || rsp_ready)

endmodule

[bench/qpht_result_checker.sv]
// result checker for the quadratic probe hash table: watches both channels,
// predicts every result from its own copy of the table; depends on qpht_pkg
`timescale 1ns / 1ps

module qpht_result_checker import qpht_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    localparam int NO_SLOT = -1;

    logic             shadow_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0] shadow_key   [TABLE_ENTRIES];
    logic [VAL_W-1:0] shadow_value [TABLE_ENTRIES];

    rsp_t expected_rsps[$];

    // walk the cumulative quadratic path from the home slot
    function automatic int find_slot(input logic [KEY_W-1:0] key,
                                     input logic [VAL_W-1:0] value,
                                     input bit want_free);
        int pos;
        pos = int'(key % TABLE_ENTRIES);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            pos = (pos + i * i) % TABLE_ENTRIES;
            if (want_free)
            begin
                if (!shadow_valid[pos])
                    return pos;
            end
            else if (shadow_valid[pos] && shadow_key[pos] == key &&
                     shadow_value[pos] == value)
            begin
                return pos;
            end
        end
        return NO_SLOT;
    endfunction

    function automatic rsp_t apply_request(input req_t item);
        rsp_t result;
        int   s;
        result.status     = STAT_MISS;
        result.slot_index = '0;
        case (item.func)
            FUNC_INSERT:
            begin
                s = find_slot(item.key, item.value, 1'b1);
                if (s != NO_SLOT)
                begin
                    shadow_valid[s]   = 1'b1;
                    shadow_key[s]     = item.key;
                    shadow_value[s]   = item.value;
                    result.status     = STAT_DONE;
                    result.slot_index = SLOT_W'(s);
                end
                else
                begin
                    result.status = STAT_FULL;
                end
            end
            FUNC_SEARCH:
            begin
                s = find_slot(item.key, item.value, 1'b0);
                if (s != NO_SLOT)
                begin
                    result.status     = STAT_DONE;
                    result.slot_index = SLOT_W'(s);
                end
            end
            FUNC_DELETE:
            begin
                s = find_slot(item.key, item.value, 1'b0);
                if (s != NO_SLOT)
                begin
                    shadow_valid[s]   = 1'b0;
                    result.status     = STAT_DONE;
                    result.slot_index = SLOT_W'(s);
                end
            end
            default:
            begin
            end
        endcase
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                shadow_valid[i] = 1'b0;
            expected_rsps.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results first: a result never belongs to an item taken at the same edge
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                             $time, rsp.status, rsp.slot_index);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.slot_index !== want.slot_index)
                    begin
                        fail_count++;
                        $display("%0t: slot_index mismatch, expected %0d actual %0d",
                                 $time, want.slot_index, rsp.slot_index);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsps.push_back(apply_request(req));
            pending = expected_rsps.size();
        end
    end

endmodule

[bench/tb_quadratic_probe_hash_table.sv]
// testbench top for the quadratic probe hash table: clock, reset, request
// stimulus and response back-pressure; depends on qpht_pkg and qpht_result_checker
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;
    import qpht_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX     = 31'h7FFF_FFFF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int KEY_POOL_SIZE = 10;
    localparam int VAL_POOL_SIZE = 3;
    localparam int HISTORY_DEPTH = 32;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    bit   quiet     = 1'b0;

    quadratic_probe_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    qpht_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        rsp_ready <= quiet || ($urandom_range(99) >= 6);

    function automatic req_t make_req(input logic [FUNC_W-1:0] func,
                                      input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] value);
        req_t r;
        r.func  = func;
        r.key   = key;
        r.value = value;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic push_item(input req_t item);
        while (!quiet && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
        logic [VAL_W-1:0] val_pool [VAL_POOL_SIZE];
        req_t             inserted[$];
        req_t             item;
        int               roll;
        int               ins_lim;
        int               srch_lim;

        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom());
        val_pool[0] = $urandom();
        val_pool[1] = $urandom();
        val_pool[2] = 32'hFFFF_FFFF;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table and the unused operation
        push_item(make_req(FUNC_SEARCH, '0, '0));
        push_item(make_req(FUNC_DELETE, KEY_MAX, 32'h8000_0000));
        push_item(make_req(FUNC_UNUSED, KEY_MAX, 32'hFFFF_FFFF));
        // home slot 0 path holds 11 distinct slots, the 12th insert finds it full
        push_item(make_req(FUNC_INSERT, 31'h0, 32'h0));
        push_item(make_req(FUNC_INSERT, 31'h0, 32'h0));
        push_item(make_req(FUNC_INSERT, 31'h7FFF_FFF0, 32'h8000_0000));
        push_item(make_req(FUNC_INSERT, 31'h10, 32'h7FFF_FFFF));
        push_item(make_req(FUNC_INSERT, 31'h5555_5550, 32'hFFFF_FFFF));
        push_item(make_req(FUNC_INSERT, 31'h2AAA_AAA0, 32'h1234_5678));
        push_item(make_req(FUNC_INSERT, 31'h20, 32'd1));
        push_item(make_req(FUNC_INSERT, 31'h30, 32'd2));
        push_item(make_req(FUNC_INSERT, 31'h40, 32'd3));
        push_item(make_req(FUNC_INSERT, 31'h50, 32'd4));
        push_item(make_req(FUNC_INSERT, 31'h60, 32'd5));
        push_item(make_req(FUNC_INSERT, 31'h70, 32'd6));
        // other slots remain free despite the full path
        push_item(make_req(FUNC_INSERT, KEY_MAX, 32'h8000_0000));
        push_item(make_req(FUNC_SEARCH, 31'h60, 32'd5));
        // open a hole in the path, search must walk past it
        push_item(make_req(FUNC_DELETE, 31'h7FFF_FFF0, 32'h8000_0000));
        push_item(make_req(FUNC_SEARCH, 31'h60, 32'd5));
        push_item(make_req(FUNC_SEARCH, 31'h60, 32'd6));
        push_item(make_req(FUNC_INSERT, 31'h70, 32'd6));
        // duplicate pair: delete the first copy, the second is still found
        push_item(make_req(FUNC_DELETE, 31'h0, 32'h0));
        push_item(make_req(FUNC_SEARCH, 31'h0, 32'h0));
        push_item(make_req(FUNC_UNUSED, 31'h0, 32'h0));
        push_item(make_req(FUNC_SEARCH, KEY_MAX, 32'h8000_0000));
        push_item(make_req(FUNC_DELETE, KEY_MAX, 32'h8000_0000));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 500 && n < 700);
            // phases cycle through filling, a balanced mix and draining the table
            case ((n / 150) % 3)
                0:
                begin
                    ins_lim  = 60;
                    srch_lim = 80;
                end
                1:
                begin
                    ins_lim  = 35;
                    srch_lim = 65;
                end
                default:
                begin
                    ins_lim  = 15;
                    srch_lim = 45;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < ins_lim)
                item.func = FUNC_INSERT;
            else if (roll < srch_lim)
                item.func = FUNC_SEARCH;
            else if (roll < 97)
                item.func = FUNC_DELETE;
            else
                item.func = FUNC_UNUSED;

            if (item.func != FUNC_INSERT && inserted.size() > 0 &&
                $urandom_range(99) < 60)
            begin
                item.key   = inserted[$urandom_range(inserted.size() - 1)].key;
                item.value = inserted[$urandom_range(inserted.size() - 1)].value;
            end
            else if ($urandom_range(99) < 80)
            begin
                item.key   = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
                item.value = val_pool[$urandom_range(VAL_POOL_SIZE - 1)];
            end
            else
            begin
                item.key   = KEY_W'($urandom());
                item.value = $urandom();
            end
            // searches, deletes and unused operations mostly pick pairs placed earlier
            if (item.func != FUNC_INSERT && inserted.size() > 0 &&
                $urandom_range(99) < 50)
                item = make_req(item.func, inserted[0].key, inserted[0].value);

            if (item.func == FUNC_INSERT)
            begin
                inserted.push_back(item);
                if (inserted.size() > HISTORY_DEPTH)
                    void'(inserted.pop_front());
            end
            push_item(item);
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_quadratic_probe_hash_table passed");
        else
            $display("tb_quadratic_probe_hash_table failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("tb_quadratic_probe_hash_table failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_ram.sv
rtl/qpht_ctrl.sv
rtl/quadratic_probe_hash_table.sv
bench/qpht_result_checker.sv
bench/tb_quadratic_probe_hash_table.sv
